// ===== hdl/plvs_pkg.sv =====
package plvs_pkg;

   localparam int WAYS     = 16;
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int CNT_W    = $clog2(WAYS + 1);
   localparam int CORE_W   = 4;
   localparam int REQ_WAY_W = 4;
   localparam int ALLOC_W  = 5;
   localparam int MASK_W   = 16;
   localparam int RSP_WAY_W = 4;
   localparam int CMP_W    = (CNT_W > ALLOC_W) ? CNT_W : ALLOC_W;
   localparam int QDEPTH   = 2;
   localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W   = $clog2(QDEPTH + 1);

   localparam logic CMD_TOUCH   = 1'b0;
   localparam logic CMD_REPLACE = 1'b1;

   // classified word handed from the front to the back
   typedef struct packed {
      logic                is_replace;
      logic                touch_ok;
      logic [CORE_W-1:0]   core;
      logic [WAY_W-1:0]    way;
      logic [ALLOC_W-1:0]  alloc;
      logic [MASK_W-1:0]   mask;
   } plvs_item_type;

endpackage

// ===== hdl/plvs_front.sv =====
module plvs_front (
   input  logic                          start,
   input  logic                          q_full,
   input  logic                          req_command,
   input  logic [plvs_pkg::CORE_W-1:0]   req_core_id,
   input  logic [plvs_pkg::REQ_WAY_W-1:0] req_way,
   input  logic [plvs_pkg::ALLOC_W-1:0]  req_allocation,
   input  logic [plvs_pkg::MASK_W-1:0]   req_replaceable_mask,
   output logic                          busy,
   output logic                          push,
   output plvs_pkg::plvs_item_type       push_item
);
   import plvs_pkg::*;

   logic [WAY_W+REQ_WAY_W-1:0] way_x;

   always_comb begin
      way_x = {{WAY_W{1'b0}}, req_way};
      busy  = q_full;
      push  = start && !q_full;
      push_item.is_replace = (req_command == CMD_REPLACE);
      // touches of ways beyond the set are dropped
      push_item.touch_ok   = (way_x < (WAY_W+REQ_WAY_W)'(WAYS));
      push_item.core       = req_core_id;
      push_item.way        = way_x[WAY_W-1:0];
      // zero allocation counts as one
      push_item.alloc      = (req_allocation == '0) ? ALLOC_W'(1) : req_allocation;
      push_item.mask       = req_replaceable_mask;
   end

endmodule

// ===== hdl/plvs_queue.sv =====
module plvs_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  plvs_pkg::plvs_item_type push_item,
   input  logic                    pop,
   output logic                    full,
   output logic                    not_empty,
   output plvs_pkg::plvs_item_type head
);
   import plvs_pkg::*;

   plvs_item_type       q_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   always_comb begin
      full      = (cnt_ff == QCNT_W'(QDEPTH));
      not_empty = (cnt_ff != '0);
      head      = q_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && not_empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/plvs_back.sv =====
module plvs_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_not_empty,
   input  plvs_pkg::plvs_item_type        q_head,
   output logic                           pop,
   output logic                           rsp_strobe,
   output logic [plvs_pkg::RSP_WAY_W-1:0] rsp_victim_way,
   output logic                           rsp_victim_found
);
   import plvs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_SCAN    = 3'b010,
      ST_PROMOTE = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   plvs_item_type        cur_ff, cur_in;
   logic [WAY_W-1:0]     scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [WAY_W-1:0]     own_rank_ff, own_rank_in;
   logic [WAY_W-1:0]     own_idx_ff, own_idx_in;
   logic [WAY_W-1:0]     oth_rank_ff, oth_rank_in;
   logic [WAY_W-1:0]     oth_idx_ff, oth_idx_in;
   logic [WAY_W-1:0]     prom_way_ff, prom_way_in;
   logic                 found_ff, found_in;
   logic [WAY_W-1:0]     rank_ff [WAYS];
   logic [WAY_W-1:0]     rank_in [WAYS];
   logic [CORE_W-1:0]    owner_ff [WAYS];
   logic [CORE_W-1:0]    owner_in [WAYS];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_WAY_W-1:0] rsp_way_ff, rsp_way_in;
   logic                 rsp_found_ff, rsp_found_in;

   logic [WAY_W-1:0]        rd_idx;
   logic [WAY_W-1:0]        rd_rank;
   logic [CORE_W-1:0]       rd_owner;
   logic [WAY_W+MASK_W-1:0] idx_x;
   logic [WAY_W+RSP_WAY_W-1:0] vic_x;
   logic                    can, mine, steal_own;
   logic [WAY_W-1:0]        sel_rank, sel_idx;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      scan_idx_in  = scan_idx_ff;
      count_in     = count_ff;
      own_rank_in  = own_rank_ff;
      own_idx_in   = own_idx_ff;
      oth_rank_in  = oth_rank_ff;
      oth_idx_in   = oth_idx_ff;
      prom_way_in  = prom_way_ff;
      found_in     = found_ff;
      rank_in      = rank_ff;
      owner_in     = owner_ff;
      rsp_valid_in = 1'b0;
      rsp_way_in   = rsp_way_ff;
      rsp_found_in = rsp_found_ff;
      pop          = 1'b0;

      // single read port: scan walks the ways, promote looks at its own way
      rd_idx   = (state_ff == ST_SCAN) ? scan_idx_ff : prom_way_ff;
      rd_rank  = rank_ff[rd_idx];
      rd_owner = owner_ff[rd_idx];

      idx_x = {{MASK_W{1'b0}}, scan_idx_ff};
      can   = (idx_x < (WAY_W+MASK_W)'(MASK_W)) && cur_ff.mask[idx_x[$clog2(MASK_W)-1:0]];
      mine  = (rd_owner == cur_ff.core);
      steal_own = 1'b0;
      sel_rank  = '0;
      sel_idx   = '0;
      vic_x     = {{RSP_WAY_W{1'b0}}, prom_way_ff};

      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               pop    = 1'b1;
               cur_in = q_head;
               if (q_head.is_replace) begin
                  scan_idx_in = '0;
                  count_in    = '0;
                  own_rank_in = '0;
                  own_idx_in  = '0;
                  oth_rank_in = '0;
                  oth_idx_in  = '0;
                  state_in    = ST_SCAN;
               end else if (q_head.touch_ok) begin
                  prom_way_in = q_head.way;
                  found_in    = 1'b0;
                  state_in    = ST_PROMOTE;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_way_in   = '0;
                  rsp_found_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            // track the oldest candidate on both sides, decide at the end
            if (mine) begin
               count_in = count_ff + CNT_W'(1);
            end
            if (can && mine && (rd_rank > own_rank_ff)) begin
               own_rank_in = rd_rank;
               own_idx_in  = scan_idx_ff;
            end
            if (can && !mine && (rd_rank > oth_rank_ff)) begin
               oth_rank_in = rd_rank;
               oth_idx_in  = scan_idx_ff;
            end
            if (scan_idx_ff == WAY_W'(WAYS-1)) begin
               steal_own   = (CMP_W'(count_in) >= CMP_W'(cur_ff.alloc));
               sel_rank    = steal_own ? own_rank_in : oth_rank_in;
               sel_idx     = steal_own ? own_idx_in : oth_idx_in;
               prom_way_in = sel_idx;
               found_in    = (sel_rank != '0);
               state_in    = ST_PROMOTE;
            end else begin
               scan_idx_in = scan_idx_ff + WAY_W'(1);
            end
         end
         ST_PROMOTE: begin
            for (int i = 0; i < WAYS; i++) begin
               if (WAY_W'(i) == prom_way_ff) begin
                  rank_in[i] = '0;
               end else if (rank_ff[i] < rd_rank) begin
                  rank_in[i] = rank_ff[i] + WAY_W'(1);
               end
            end
            if (cur_ff.is_replace) begin
               owner_in[prom_way_ff] = cur_ff.core;
            end
            rsp_valid_in = 1'b1;
            rsp_way_in   = cur_ff.is_replace ? vic_x[RSP_WAY_W-1:0] : '0;
            rsp_found_in = cur_ff.is_replace && found_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_strobe       = rsp_valid_ff;
      rsp_victim_way   = rsp_way_ff;
      rsp_victim_found = rsp_found_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WAYS; i++) begin
            rank_ff[i]  <= WAY_W'(i);
            owner_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rank_ff      <= rank_in;
         owner_ff     <= owner_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      scan_idx_ff  <= scan_idx_in;
      count_ff     <= count_in;
      own_rank_ff  <= own_rank_in;
      own_idx_ff   <= own_idx_in;
      oth_rank_ff  <= oth_rank_in;
      oth_idx_ff   <= oth_idx_in;
      prom_way_ff  <= prom_way_in;
      found_ff     <= found_in;
      rsp_way_ff   <= rsp_way_in;
      rsp_found_ff <= rsp_found_in;
   end

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE))
      else $error("queue popped while a word is in progress");

   a_scan_continues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && (scan_idx_ff != WAY_W'(WAYS-1)) |=> (state_ff == ST_SCAN))
      else $error("scan left before the last way");

   a_promoted_is_newest: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROMOTE) |=> (rank_ff[$past(prom_way_ff)] == '0))
      else $error("promoted way is not most recent");

   a_found_from_replace: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> $past((state_ff == ST_PROMOTE) && cur_ff.is_replace))
      else $error("victim found flagged on a touch");

endmodule

// ===== hdl/partitioned_lru_victim_select_top.sv =====
// Way-partitioned LRU replacement for one cache set. Each start with busy low
// takes one word into a two-entry queue; busy is high while that queue is full.
// Words are executed in order and each gives exactly one response, shown for a
// single cycle with rsp_strobe high; the receiver cannot hold it off. A touch
// is issued and then promoted once at the head of the queue (a touch of a way
// outside the set answers at issue); a replace is issued, walks the rank and owner
// scan one way per cycle, and then promotes the victim and hands it to the
// requester. The response is registered and shown in the cycle after that.
module partitioned_lru_victim_select_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_command,
   input  logic [plvs_pkg::CORE_W-1:0]     req_core_id,
   input  logic [plvs_pkg::REQ_WAY_W-1:0]  req_way,
   input  logic [plvs_pkg::ALLOC_W-1:0]    req_allocation,
   input  logic [plvs_pkg::MASK_W-1:0]     req_replaceable_mask,
   output logic                            rsp_strobe,
   output logic [plvs_pkg::RSP_WAY_W-1:0]  rsp_victim_way,
   output logic                            rsp_victim_found
);
   import plvs_pkg::*;

   logic          q_full, q_not_empty, push, pop;
   plvs_item_type push_item, q_head;

   plvs_front u_front (
      .start                (start),
      .q_full               (q_full),
      .req_command          (req_command),
      .req_core_id          (req_core_id),
      .req_way              (req_way),
      .req_allocation       (req_allocation),
      .req_replaceable_mask (req_replaceable_mask),
      .busy                 (busy),
      .push                 (push),
      .push_item            (push_item)
   );

   plvs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   plvs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .q_head           (q_head),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_victim_way   (rsp_victim_way),
      .rsp_victim_found (rsp_victim_found)
   );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   import plvs_pkg::*;

   localparam int IDLE_LIMIT   = 1000;
   localparam int RANDOM_WORDS = 1200;
   localparam int DRAIN_CYCLES = 24;

   typedef struct packed {
      logic               command;
      logic [CORE_W-1:0]  core;
      logic [REQ_WAY_W-1:0] way;
      logic [ALLOC_W-1:0] alloc;
      logic [MASK_W-1:0]  mask;
   } victim_req_type;

   typedef struct packed {
      logic [RSP_WAY_W-1:0] way;
      logic                 found;
   } victim_rsp_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_command;
   logic [CORE_W-1:0]      req_core_id;
   logic [REQ_WAY_W-1:0]   req_way;
   logic [ALLOC_W-1:0]     req_allocation;
   logic [MASK_W-1:0]      req_replaceable_mask;
   logic                   rsp_strobe;
   logic [RSP_WAY_W-1:0]   rsp_victim_way;
   logic                   rsp_victim_found;

   victim_req_type  pending_words[$];
   victim_rsp_type  expected_victims[$];

   // shadow of the set's replacement state
   logic [WAY_W-1:0]   way_rank [WAYS];
   logic [CORE_W-1:0]  way_core [WAYS];

   int fail_cnt;
   int accepted_cnt;
   int stall_cycles;

   partitioned_lru_victim_select_top i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_command          (req_command),
      .req_core_id          (req_core_id),
      .req_way              (req_way),
      .req_allocation       (req_allocation),
      .req_replaceable_mask (req_replaceable_mask),
      .rsp_strobe           (rsp_strobe),
      .rsp_victim_way       (rsp_victim_way),
      .rsp_victim_found     (rsp_victim_found)
   );

   always #10 clock = ~clock;

   function automatic void make_recent(int w);
      logic [WAY_W-1:0] r;
      r = way_rank[w];
      for (int i = 0; i < WAYS; i++) begin
         if (way_rank[i] < r) way_rank[i] = way_rank[i] + 1'b1;
      end
      way_rank[w] = '0;
   endfunction

   function automatic victim_rsp_type pick_victim(victim_req_type r);
      victim_rsp_type res;
      int          owned;
      int          quota;
      int          best;
      int          victim;
      logic        take_own;
      logic        can_go;
      res = '0;
      owned = 0;
      best = 0;
      victim = 0;
      if (r.command == CMD_TOUCH) begin
         if (int'(r.way) < WAYS) make_recent(int'(r.way));
         return res;
      end
      for (int i = 0; i < WAYS; i++) begin
         if (way_core[i] == r.core) owned++;
      end
      quota = (r.alloc == '0) ? 1 : int'(r.alloc);
      take_own = (owned >= quota);
      for (int i = 0; i < WAYS; i++) begin
         // ways beyond the mask width are never replaceable
         can_go = (i < MASK_W) && r.mask[i];
         if (can_go && int'(way_rank[i]) > best && ((way_core[i] == r.core) == take_own)) begin
            victim = i;
            best = int'(way_rank[i]);
         end
      end
      make_recent(victim);
      way_core[victim] = r.core;
      res.way = RSP_WAY_W'(victim);
      res.found = (best > 0);
      return res;
   endfunction

   task automatic add_word(logic cmd, int core, int way, int alloc, int mask);
      victim_req_type w;
      w.command = cmd;
      w.core = CORE_W'(core);
      w.way = REQ_WAY_W'(way);
      w.alloc = ALLOC_W'(alloc);
      w.mask = MASK_W'(mask);
      pending_words.push_back(w);
   endtask

   task automatic report_failure(string what);
      if (fail_cnt < 10) $display("%0t: %s", $realtime, what);
      fail_cnt++;
   endtask

   // driver: one word at a time from the pending queue, random gaps except while words 500 to 799 are taken
   always @(negedge clock) begin
      logic quiet;
      quiet = (accepted_cnt >= 500) && (accepted_cnt < 800);
      if (reset || pending_words.size() == 0 || (!quiet && $urandom_range(99) < 32)) begin
         start <= 1'b0;
      end else begin
         start                <= 1'b1;
         req_command          <= pending_words[0].command;
         req_core_id          <= pending_words[0].core;
         req_way              <= pending_words[0].way;
         req_allocation       <= pending_words[0].alloc;
         req_replaceable_mask <= pending_words[0].mask;
      end
   end

   // monitor: predicts on acceptance, checks each strobed response
   always @(posedge clock) begin
      victim_req_type taken;
      victim_rsp_type want;
      logic        moved;
      if (!reset) begin
         moved = 1'b0;
         if (start && !busy) begin
            taken = {req_command, req_core_id, req_way, req_allocation, req_replaceable_mask};
            expected_victims.push_back(pick_victim(taken));
            void'(pending_words.pop_front());
            accepted_cnt++;
            moved = 1'b1;
         end
         if (rsp_strobe) begin
            moved = 1'b1;
            if (expected_victims.size() == 0) begin
               report_failure($sformatf("unexpected response way=%0d found=%0d",
                                        rsp_victim_way, rsp_victim_found));
            end else begin
               want = expected_victims.pop_front();
               if (rsp_victim_way !== want.way || rsp_victim_found !== want.found)
                  report_failure($sformatf("mismatch: exp way=%0d found=%0d, got way=%0d found=%0d",
                                           want.way, want.found,
                                           rsp_victim_way, rsp_victim_found));
            end
         end
         stall_cycles = moved ? 0 : stall_cycles + 1;
         if (stall_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int  mix;
      int  core;
      int  mask;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_TOUCH;
      req_core_id = '0;
      req_way = '0;
      req_allocation = '0;
      req_replaceable_mask = '0;
      fail_cnt = 0;
      accepted_cnt = 0;
      stall_cycles = 0;
      for (int i = 0; i < WAYS; i++) begin
         way_rank[i] = WAY_W'(i);
         way_core[i] = '0;
      end

      // directed words
      add_word(CMD_TOUCH,    0,  0,  0, 16'h0000);
      add_word(CMD_TOUCH,   15, 15, 31, 16'hffff);
      add_word(CMD_TOUCH,    5,  7,  3, 16'h1234);
      add_word(CMD_REPLACE,  0,  0,  0, 16'hffff);   // core 0 owns every way
      add_word(CMD_REPLACE, 15, 15, 16, 16'hffff);   // under quota, takes from others
      add_word(CMD_REPLACE,  3,  9,  1, 16'h0000);   // nothing replaceable
      add_word(CMD_REPLACE,  3,  2, 31, 16'hffff);
      add_word(CMD_REPLACE,  3,  0, 16, 16'h0001);
      add_word(CMD_TOUCH,    0,  9,  0, 16'h0000);
      add_word(CMD_REPLACE,  9,  4,  1, 16'h0200);   // only candidate is most recent
      add_word(CMD_REPLACE,  0, 11,  0, 16'h8001);
      add_word(CMD_REPLACE, 12,  1,  2, 16'haaaa);
      add_word(CMD_REPLACE, 12,  6,  2, 16'h5555);
      add_word(CMD_REPLACE, 12,  3,  1, 16'hffff);   // at quota, evicts own way
      add_word(CMD_TOUCH,    0, 15,  0, 16'h0000);
      add_word(CMD_REPLACE,  0,  8,  0, 16'h8000);
      add_word(CMD_REPLACE,  7, 12, 17, 16'h7ffe);
      add_word(CMD_REPLACE, 15, 14,  8, 16'hffff);

      // random words: a handful of busy cores so ownership builds up
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         core = ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(15);
         mix = $urandom_range(3);
         case (mix)
            0: mask = 16'hffff;
            1: mask = (1 << $urandom_range(15)) | (1 << $urandom_range(15));
            default: mask = $urandom_range(16'hffff);
         endcase
         add_word($urandom_range(1) ? CMD_REPLACE : CMD_TOUCH, core, $urandom_range(15),
                  ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(16), mask);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || expected_victims.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_cnt == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
